### sv/scc_pkg.sv
// ============================================================================
// scc_pkg: shared types and constants for the sector cache
// Command codes, queue item type, back-end state encoding and beat layout.
// ============================================================================
package scc_pkg;

    // default sizing
    localparam int SLOTS_DEFAULT       = 64;
    localparam int SECTOR_BITS_DEFAULT = 32;

    // fixed field widths on the stream ports
    localparam int CMD_W      = 2;
    localparam int SECTOR_W   = 32;
    localparam int SLOT_OUT_W = 6;

    // input beat: cmd, sector, zero padding to whole bytes
    localparam int IN_FIELDS_W = CMD_W + SECTOR_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // output beat: slot, hit, evict_write, evict_sector, fill_needed, padding
    localparam int OUT_FIELDS_W = SLOT_OUT_W + 1 + 1 + SECTOR_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // command queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // command codes on the input beat
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // classified command kind
    typedef enum logic [1:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_FLUSH
    } kind_t;

    // queue entry handed from front to back
    typedef struct packed {
        kind_t                kind;
        logic [SECTOR_W-1:0]  sector;
    } item_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESOLVE,
        ST_SWEEP,
        ST_INSTALL,
        ST_FLUSH,
        ST_FLUSH_EMIT
    } state_t;

endpackage

### sv/scc_front.sv
// ============================================================================
// scc_front: command intake and queue
// Accepts input beats, classifies the command and queues read, write and
// flush work for the back end; unused command codes are dropped.
// ============================================================================
module scc_front
    import scc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [1:0] cmd, [33:2] sector
    output logic                  q_valid,
    output item_t                 q_item,
    input  logic                  q_pop
);

    item_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    logic                  accept;
    logic                  push;
    logic                  pop;
    kind_t                 kind;
    logic [CMD_W-1:0]      cmd;
    logic [SECTOR_W-1:0]   sector;

    // unpack and classify the incoming beat
    assign cmd    = s_axis_tdata[CMD_W-1:0];
    assign sector = s_axis_tdata[CMD_W +: SECTOR_W];

    always_comb
    begin
        kind = KIND_READ;
        push = 1'b0;
        case (cmd)
            CMD_READ:
            begin
                kind = KIND_READ;
                push = accept;
            end
            CMD_WRITE:
            begin
                kind = KIND_WRITE;
                push = accept;
            end
            CMD_FLUSH:
            begin
                kind = KIND_FLUSH;
                push = accept;
            end
            default:
            begin
                kind = KIND_READ;
                push = 1'b0;
            end
        endcase
    end

    // handshake and queue pointers
    assign s_axis_tready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{kind: kind, sector: sector};
        end
    end

endmodule

### sv/scc_back.sv
// ============================================================================
// scc_back: tag store and clock replacement engine
// Holds tags and per-slot valid, dirty and reference bits, runs the tag
// compare, the clock hand sweep and the flush scan, and drives result beats.
// ============================================================================
module scc_back
    import scc_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEFAULT,
    parameter int SECTOR_BITS = SECTOR_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [5:0] slot, [6] hit, [7] evict_write, [39:8] evict_sector, [40] fill_needed
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TAG_W  = (SECTOR_BITS > SECTOR_W) ? SECTOR_W : SECTOR_BITS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // tag store, one comparator per entry plus one read port whose data is registered in old_reg
    logic [TAG_W-1:0]      tag_reg [SLOTS];
    logic                  tag_we;
    logic [SLOT_W-1:0]     tag_raddr;

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [TAG_W-1:0]      sec_reg, sec_next;
    logic [SLOTS-1:0]      match_reg, match_next;
    logic [SLOTS-1:0]      mask_reg, mask_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [SLOTS-1:0]      dirty_reg, dirty_next;
    logic [SLOTS-1:0]      ref_reg, ref_next;
    logic [SLOT_W-1:0]     hand_reg, hand_next;
    logic [SLOT_W-1:0]     victim_reg, victim_next;
    logic                  wb_reg, wb_next;
    logic                  flush_last_reg, flush_last_next;
    logic [TAG_W-1:0]      old_reg, old_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_ew_reg, out_ew_next;
    logic [SECTOR_W-1:0]   out_es_reg, out_es_next;
    logic                  out_fill_reg, out_fill_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  emit;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     fl_idx;
    logic [SLOTS-1:0]      mask_rest;
    logic [SLOT_W-1:0]     hand_inc;

    // lowest matching slot and lowest slot left to flush
    always_comb
    begin
        hit_idx = '0;
        fl_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (mask_reg[i])
            begin
                fl_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        mask_rest         = mask_reg;
        mask_rest[fl_idx] = 1'b0;
    end

    assign hand_inc  = (hand_reg == LAST_SLOT) ? '0 : hand_reg + 1'b1;
    assign tag_raddr = (state_reg == ST_FLUSH) ? fl_idx : hand_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // sequencer: next state, slot metadata and result beat
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sec_next        = sec_reg;
        match_next      = match_reg;
        mask_next       = mask_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        ref_next        = ref_reg;
        hand_next       = hand_reg;
        victim_next     = victim_reg;
        wb_next         = wb_reg;
        flush_last_next = flush_last_reg;
        old_next        = old_reg;
        q_pop           = 1'b0;
        tag_we          = 1'b0;
        emit            = 1'b0;
        out_slot_next   = out_slot_reg;
        out_hit_next    = out_hit_reg;
        out_ew_next     = out_ew_reg;
        out_es_next     = out_es_reg;
        out_fill_next   = out_fill_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_item.kind;
                    sec_next  = q_item.sector[TAG_W-1:0];
                    if (q_item.kind == KIND_FLUSH)
                    begin
                        mask_next  = valid_reg & dirty_reg;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    match_next[i] = valid_reg[i] && (tag_reg[i] == sec_reg);
                end
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (match_reg != '0)
                begin
                    if (out_free)
                    begin
                        ref_next[hit_idx] = 1'b1;
                        if (kind_reg == KIND_WRITE)
                        begin
                            dirty_next[hit_idx] = 1'b1;
                        end
                        emit          = 1'b1;
                        out_slot_next = SLOT_OUT_W'(hit_idx);
                        out_hit_next  = 1'b1;
                        out_ew_next   = 1'b0;
                        out_es_next   = '0;
                        out_fill_next = 1'b0;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // a referenced slot gets its second chance and is passed over
                hand_next = hand_inc;
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                end
                else
                begin
                    victim_next = hand_reg;
                    wb_next     = valid_reg[hand_reg] && dirty_reg[hand_reg];
                    old_next    = tag_reg[tag_raddr];
                    state_next  = ST_INSTALL;
                end
            end
            ST_INSTALL:
            begin
                if (out_free)
                begin
                    tag_we                 = 1'b1;
                    valid_next[victim_reg] = 1'b1;
                    ref_next[victim_reg]   = 1'b1;
                    dirty_next[victim_reg] = (kind_reg == KIND_WRITE);
                    emit                   = 1'b1;
                    out_slot_next          = SLOT_OUT_W'(victim_reg);
                    out_hit_next           = 1'b0;
                    out_ew_next            = wb_reg;
                    out_es_next            = wb_reg ? SECTOR_W'(old_reg) : '0;
                    out_fill_next          = (kind_reg == KIND_READ);
                    out_last_next          = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    victim_next        = fl_idx;
                    old_next           = tag_reg[tag_raddr];
                    flush_last_next    = (mask_rest == '0);
                    mask_next          = mask_rest;
                    valid_next[fl_idx] = 1'b0;
                    dirty_next[fl_idx] = 1'b0;
                    state_next         = ST_FLUSH_EMIT;
                end
            end
            ST_FLUSH_EMIT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_slot_next = SLOT_OUT_W'(victim_reg);
                    out_hit_next  = 1'b0;
                    out_ew_next   = 1'b1;
                    out_es_next   = SECTOR_W'(old_reg);
                    out_fill_next = 1'b0;
                    out_last_next = flush_last_reg;
                    state_next    = flush_last_reg ? ST_IDLE : ST_FLUSH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register: load on emit, drain when taken
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            ref_reg       <= '0;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            ref_reg       <= ref_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        sec_reg        <= sec_next;
        match_reg      <= match_next;
        mask_reg       <= mask_next;
        victim_reg     <= victim_next;
        wb_reg         <= wb_next;
        flush_last_reg <= flush_last_next;
        old_reg        <= old_next;
        out_slot_reg   <= out_slot_next;
        out_hit_reg    <= out_hit_next;
        out_ew_reg     <= out_ew_next;
        out_es_reg     <= out_es_next;
        out_fill_reg   <= out_fill_next;
        out_last_reg   <= out_last_next;
    end

    // tag write on install
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_reg[victim_reg] <= sec_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_fill_reg, out_es_reg, out_ew_reg,
                            out_hit_reg, out_slot_reg};

endmodule

### sv/sector_cache_clock_replacement_top.sv
// Lookup: a hit passes ST_IDLE, ST_LOOKUP and ST_RESOLVE to its result beat; a miss adds ST_SWEEP and
// ST_INSTALL, the clock hand passing one slot per cycle (1 to SLOTS + 1 slots examined).
// Flush: each dirty slot passes through ST_FLUSH, which reads its tag, then ST_FLUSH_EMIT, which sends its beat.
// Throughput: one command in the back end at a time; a 2-entry queue keeps intake open.
// Reset: valid, dirty and reference bits, the hand and all handshake state clear at once;
// tags are not cleared and their values are used only for valid slots.
// ============================================================================
// sector_cache_clock_replacement_top: sector cache tag manager
// Clock (second chance) replacement over a tag store; read, write and flush
// commands in, hit / install / writeback result beats out.
// ============================================================================
module sector_cache_clock_replacement_top
    import scc_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEFAULT,
    parameter int SECTOR_BITS = SECTOR_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] cmd, [33:2] sector
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [5:0] slot, [6] hit, [7] evict_write, [39:8] evict_sector, [40] fill_needed
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // intake and classification
    scc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // lookup, replacement and flush engine
    scc_back #(
        .SLOTS       (SLOTS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // back end only dequeues work that is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a fill request comes only on a miss and closes its command
    a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[40]) |-> (!m_axis_tdata[6] && m_axis_tlast))
        else $error("fill request on a hit or not last");

    // a hit never evicts and is the only beat of its command
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |-> (!m_axis_tdata[7] && m_axis_tlast))
        else $error("hit beat with writeback or not last");

    // evicted sector reads zero unless a writeback is reported
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tdata[39:8] == '0))
        else $error("evict sector set without writeback");

endmodule
